// ----- src/sorted_priority_queue_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define SPQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default number of queue entries.
  localparam int CAPACITY_DEF = 16;
  // Default number of priority bits kept per entry.
  localparam int PRIORITY_BITS_DEF = 8;

  // Width of the priority port and of the result occupancy.
  localparam int PRIO_PORT_W = 8;
  localparam int OCC_W       = 5;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_REMOVED   = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } status_e;

  // Operation codes of an input transaction.
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_e;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // update the cells and the result registers
  } cmd_t;

endpackage

// ----- src/spq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller of the priority queue: accepts a transaction, runs the execute
// state in the datapath and raises the result strobe.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_top_defines.svh"

module spq_ctrl
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output cmd_t cmd_o,
  output logic done_o
);

  state_e state_q, state_d;
  logic   done_q;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    busy       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The result strobe is registered and rises in the cycle after the execute cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_o.exec;
    end
  end

  assign done_o = done_q;

  `SPQ_ASSERT_NEXT(a_accept_exec, start && !busy, state_q == S_EXEC, "accept must lead to execute")
  `SPQ_ASSERT_NEXT(a_exec_done, state_q == S_EXEC, done_q && state_q == S_IDLE, "execute must strobe")
  `SPQ_ASSERT_IMPLIES(a_done_not_busy, done_q, !busy, "strobe cycle must be able to accept")

endmodule

// ----- src/spq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Row of compare-and-shift cells holding the queue in service order, with
// the request and result registers.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_top_defines.svh"

module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  input  logic                   kind_i,
  input  logic signed [31:0]     value_in_i,
  input  logic [PRIO_PORT_W-1:0] priority_in_i,
  output logic signed [31:0]     value_out_o,
  output logic [PRIO_PORT_W-1:0] priority_out_o,
  output logic [1:0]             status_o,
  output logic [OCC_W-1:0]       occupancy_o
);

  // Priority bits actually stored, and the entry counter width.
  localparam int PW = (PRIORITY_BITS < PRIO_PORT_W) ? PRIORITY_BITS : PRIO_PORT_W;
  localparam int CW = $clog2(CAPACITY + 1);

  // Captured request.
  logic              req_kind_q;
  logic [31:0]       req_val_q;
  logic [PW-1:0]     req_pri_q;

  // Cells, slot 0 is the head.
  logic [31:0]       cell_val_q [CAPACITY];
  logic [PW-1:0]     cell_pri_q [CAPACITY];
  logic [CW-1:0]     count_q, count_d;

  // Result registers.
  logic [31:0]       res_val_q, res_val_d;
  logic [PW-1:0]     res_pri_q, res_pri_d;
  status_e           res_status_q, res_status_d;

  logic              full, empty, do_ins, do_del;
  logic [CAPACITY-1:0] take;

  assign full   = (count_q == CW'(CAPACITY));
  assign empty  = (count_q == '0);
  assign do_ins = cmd_i.exec && (req_kind_q == KIND_INSERT) && !full;
  assign do_del = cmd_i.exec && (req_kind_q == KIND_DELETE) && !empty;

  // Capture the transaction when it is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_kind_q <= kind_i;
      req_val_q  <= value_in_i;
      req_pri_q  <= priority_in_i[PW-1:0];
    end
  end

  // Each cell decides locally: it moves when it is free or holds a strictly
  // larger priority, which keeps equal priorities in arrival order.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign take[i] = (CW'(i) >= count_q) || (cell_pri_q[i] > req_pri_q);

    always_ff @(posedge clk_i) begin
      if (do_ins && take[i]) begin
        if (i == 0) begin
          cell_val_q[i] <= req_val_q;
          cell_pri_q[i] <= req_pri_q;
        end else if (!take[(i == 0) ? 0 : i - 1]) begin
          cell_val_q[i] <= req_val_q;
          cell_pri_q[i] <= req_pri_q;
        end else begin
          cell_val_q[i] <= cell_val_q[(i == 0) ? 0 : i - 1];
          cell_pri_q[i] <= cell_pri_q[(i == 0) ? 0 : i - 1];
        end
      end else if (do_del && (i < CAPACITY - 1)) begin
        cell_val_q[i] <= cell_val_q[(i < CAPACITY - 1) ? i + 1 : i];
        cell_pri_q[i] <= cell_pri_q[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  // Result and counter update for the executed transaction.
  always_comb begin
    count_d      = count_q;
    res_val_d    = '0;
    res_pri_d    = '0;
    res_status_d = STAT_INSERTED;
    case (req_kind_q)
      KIND_INSERT: begin
        if (full) begin
          res_status_d = STAT_OVERFLOW;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      default: begin
        if (empty) begin
          res_status_d = STAT_UNDERFLOW;
        end else begin
          res_status_d = STAT_REMOVED;
          res_val_d    = cell_val_q[0];
          res_pri_d    = cell_pri_q[0];
          count_d      = count_q - CW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_val_q    <= res_val_d;
      res_pri_q    <= res_pri_d;
      res_status_q <= res_status_d;
    end
  end

  // Output formatting: zero-extend the priority, wrap the occupancy.
  logic [PW+PRIO_PORT_W-1:0] pri_ext;
  logic [CW+OCC_W-1:0]       occ_ext;

  assign pri_ext        = {{PRIO_PORT_W{1'b0}}, res_pri_q};
  assign occ_ext        = {{OCC_W{1'b0}}, count_q};
  assign value_out_o    = res_val_q;
  assign priority_out_o = pri_ext[PRIO_PORT_W-1:0];
  assign status_o       = res_status_q;
  assign occupancy_o    = occ_ext[OCC_W-1:0];

  `SPQ_ASSERT_IMPLIES(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
  `SPQ_ASSERT_IMPLIES(a_head_order, count_q >= CW'(2), cell_pri_q[0] <= cell_pri_q[1], "head out of order")
  `SPQ_ASSERT_NEXT(a_overflow, cmd_i.exec && (req_kind_q == KIND_INSERT) && full, (res_status_q == STAT_OVERFLOW) && (count_q == CW'(CAPACITY)), "full insert must overflow")
  `SPQ_ASSERT_NEXT(a_idle_count, !cmd_i.exec, count_q == $past(count_q), "count moved without execute")

endmodule

// ----- src/sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue kept in sorted order in a row of compare-and-shift
// cells.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is accepted at a rising edge where start is high and busy is
// low. kind_i selects insert (value and priority are stored) or delete (the
// head entry is removed). A lower priority number is served first; equal
// priorities leave in arrival order.
// Every transaction gives one result, shown on the result ports for exactly
// one cycle while done_o is high. value_out_o and priority_out_o carry the
// removed entry and are zero otherwise; status_o reports inserted, removed,
// underflow or overflow; occupancy_o is the entry count after the
// transaction. An insert into a full queue is dropped.
// Timing: the accepting edge starts the execute state, from which done_o is
// registered. busy is high in the execute state, so a transaction is not
// taken before the last one is through its accept and execute steps; in the
// execute step every cell compares and shifts at once. The next transaction
// can be accepted in the cycle where the previous result is shown.
// Reset empties the queue at once; no clearing pass is needed. The receiver
// cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind_i,
  input  logic signed [31:0]     value_in_i,
  input  logic [PRIO_PORT_W-1:0] priority_in_i,
  output logic                   done_o,
  output logic signed [31:0]     value_out_o,
  output logic [PRIO_PORT_W-1:0] priority_out_o,
  output logic [1:0]             status_o,
  output logic [OCC_W-1:0]       occupancy_o
);

  cmd_t cmd;

  // Sequencing of each transaction.
  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  // Cell row and result registers.
  spq_datapath #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .value_in_i     (value_in_i),
    .priority_in_i  (priority_in_i),
    .value_out_o    (value_out_o),
    .priority_out_o (priority_out_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted priority queue. It sends a directed run
// through the empty, full, tie and extreme-value cases, then random insert
// and delete traffic with a drifting insert/delete mix. A behavioral copy of
// the queue predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH  = CAPACITY_DEF;
  localparam int RANDOM_COUNT = 750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [PRIO_PORT_W-1:0] PRIO_KEEP =
    PRIO_PORT_W'((64'd1 << PRIORITY_BITS_DEF) - 64'd1);

  // One command transaction as it is put on the input ports.
  typedef struct {
    kind_e                   kind;
    logic signed [31:0]      value;
    logic [PRIO_PORT_W-1:0]  prio;
  } queue_command_t;

  // One result transaction as the block should present it.
  typedef struct {
    logic signed [31:0]      value;
    logic [PRIO_PORT_W-1:0]  prio;
    status_e                 status;
    logic [OCC_W-1:0]        occupancy;
  } queue_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   start         = 1'b0;
  logic                   kind_i        = KIND_INSERT;
  logic signed [31:0]     value_in_i    = '0;
  logic [PRIO_PORT_W-1:0] priority_in_i = '0;
  logic                   busy;
  logic                   done_o;
  logic signed [31:0]     value_out_o;
  logic [PRIO_PORT_W-1:0] priority_out_o;
  logic [1:0]             status_o;
  logic [OCC_W-1:0]       occupancy_o;

  queue_command_t queued_commands[$];
  queue_result_t  awaited_results[$];
  int             command_total  = 1;
  int             accepted_count = 0;
  int             mismatch_count = 0;
  int             cycle_count    = 0;

  // Entries held by the behavioral queue, slot 0 is the head.
  logic signed [31:0]     held_values[QUEUE_DEPTH];
  logic [PRIO_PORT_W-1:0] held_prios[QUEUE_DEPTH];
  int                     held_count = 0;

  sorted_priority_queue_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .value_in_i    (value_in_i),
    .priority_in_i (priority_in_i),
    .done_o        (done_o),
    .value_out_o   (value_out_o),
    .priority_out_o(priority_out_o),
    .status_o      (status_o),
    .occupancy_o   (occupancy_o)
  );

  // Free-running clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Applies one command to the behavioral queue and returns its result.
  function automatic queue_result_t apply_queue_command(queue_command_t cmd);
    queue_result_t          res;
    logic [PRIO_PORT_W-1:0] prio;
    int                     pos;
    prio          = cmd.prio & PRIO_KEEP;
    res.value     = '0;
    res.prio      = '0;
    if (cmd.kind == KIND_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = STAT_OVERFLOW;
      end else begin
        // Equal priorities go behind the ones already held.
        pos = 0;
        while (pos < held_count && held_prios[pos] <= prio) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_values[i] = held_values[i-1];
          held_prios[i]  = held_prios[i-1];
        end
        held_values[pos] = cmd.value;
        held_prios[pos]  = prio;
        held_count++;
        res.status = STAT_INSERTED;
      end
    end else begin
      if (held_count == 0) begin
        res.status = STAT_UNDERFLOW;
      end else begin
        res.value = held_values[0];
        res.prio  = held_prios[0];
        for (int i = 1; i < held_count; i++) begin
          held_values[i-1] = held_values[i];
          held_prios[i-1]  = held_prios[i];
        end
        held_count--;
        res.status = STAT_REMOVED;
      end
    end
    res.occupancy = OCC_W'(held_count);
    return res;
  endfunction

  function automatic void push_command(kind_e kind, logic signed [31:0] value,
                                       logic [PRIO_PORT_W-1:0] prio);
    queue_command_t cmd;
    cmd.kind  = kind;
    cmd.value = value;
    cmd.prio  = prio;
    queued_commands.push_back(cmd);
  endfunction

  // Driver: records each accepted transaction and presents the next command.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    queue_command_t cmd;
    bit             taken;
    int             phase;
    int             idle_pct;
    if (!rst_ni) begin
      start         <= 1'b0;
      kind_i        <= KIND_INSERT;
      value_in_i    <= '0;
      priority_in_i <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        cmd.kind  = kind_e'(kind_i);
        cmd.value = value_in_i;
        cmd.prio  = priority_in_i;
        awaited_results.push_back(apply_queue_command(cmd));
        accepted_count++;
      end
      // Idle phases: none, sender idle often, receiver stall (cannot apply,
      // so no idling), and light idling on the sender.
      phase = (accepted_count * 4) / command_total;
      case (phase)
        1:       idle_pct = 61;
        3:       idle_pct = 14;
        default: idle_pct = 0;
      endcase
      if (start && !taken) begin
        // Keep the command on the ports until it is accepted.
      end else if (queued_commands.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cmd = queued_commands.pop_front();
        start         <= 1'b1;
        kind_i        <= cmd.kind;
        value_in_i    <= cmd.value;
        priority_in_i <= cmd.prio;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("[%0d] %s", cycle_count, what);
  endtask

  // Monitor: every result transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    queue_result_t exp_res;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d prio=%0d status=%0d occ=%0d",
                                  value_out_o, priority_out_o, status_o, occupancy_o));
      end else begin
        exp_res = awaited_results.pop_front();
        if (value_out_o !== exp_res.value || priority_out_o !== exp_res.prio ||
            status_o !== exp_res.status || occupancy_o !== exp_res.occupancy) begin
          report_mismatch($sformatf(
            "expected value=%0d prio=%0d status=%0d occ=%0d, got value=%0d prio=%0d status=%0d occ=%0d",
            exp_res.value, exp_res.prio, exp_res.status, exp_res.occupancy,
            value_out_o, priority_out_o, status_o, occupancy_o));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int insert_pct;
    // Delete from an empty queue.
    push_command(KIND_DELETE, 32'sh1234_5678, 8'hff);
    // Extreme values and priorities, then ties in arrival order.
    push_command(KIND_INSERT, 32'sh7fff_ffff, 8'hff);
    push_command(KIND_INSERT, 32'sh8000_0000, 8'h00);
    push_command(KIND_INSERT, 32'sh0000_0000, 8'h80);
    push_command(KIND_INSERT, -32'sd1,        8'h80);
    push_command(KIND_INSERT, 32'sd5,         8'h80);
    push_command(KIND_INSERT, 32'sd1,         8'h00);
    // Fill the rest of the queue with alternating bit patterns.
    for (int i = 0; i < QUEUE_DEPTH - 6; i++) begin
      push_command(KIND_INSERT, (i % 2) ? 32'shaaaa_aaaa : 32'sh5555_5555,
                   (i % 2) ? 8'haa : 8'h55);
    end
    // Insert into a full queue is dropped.
    push_command(KIND_INSERT, 32'sd123, 8'h03);
    for (int i = 0; i < 5; i++) push_command(KIND_DELETE, '0, '0);

    // Random traffic in chunks, each with its own insert/delete mix so that
    // the queue swings between empty and full.
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          default: insert_pct = 80;
        endcase
      end
      push_command(($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_DELETE,
                   $urandom,
                   $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255)));
    end
    command_total = queued_commands.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (queued_commands.size() != 0 || start) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sorted_priority_queue_top.f -----
+incdir+src
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/sorted_priority_queue_top.sv
bench/testbench.sv
